@@ hdl/uqp_pkg.sv @@
// Shared types, constants and decode functions of the URL query pair parser.
package uqp_pkg;

   localparam int MAX_SEGMENT = 4079;
   localparam int COUNT_W = $clog2(MAX_SEGMENT + 1);
   localparam int SPACES_W = 12;
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W = $clog2(MAX_RESULTS);
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_TAG = 1'b1;
   localparam logic [7:0] SEPARATOR_RESET = 8'd38;
   localparam logic [1:0] SOURCE_TAG_RESET = 2'd0;

   localparam logic [1:0] KIND_NAME = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [SPACES_W-1:0] SPACES_MAX = '1;

   typedef enum logic [2:0] {
      PH_BOUNDARY,
      PH_SKIP,
      PH_NAME,
      PH_VLEAD,
      PH_VBODY
   } phase_type;

   typedef enum logic [1:0] {
      HEX_IDLE,
      HEX_FIRST,
      HEX_SECOND
   } hex_phase_type;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       is_last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [7:0]          data_byte;
      logic [SPACES_W-1:0] spaces_before;
      logic                pair_valid;
      logic [1:0]          origin_tag;
      logic                last_of_run;
   } rsp_item_type;

   typedef struct packed {
      phase_type           phase;
      hex_phase_type       hex;
      logic [7:0]          held_hex_char;
      logic [COUNT_W-1:0]  decoded_count;
      logic [SPACES_W-1:0] pending_spaces;
      logic                saw_equals;
      logic                field_killed;
      logic                swallow_separator;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '0;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          data;
      logic [SPACES_W-1:0] spaces;
      logic                valid;
   } slot_type;

   // All results that one input beat causes, oldest in slot 0.
   typedef struct packed {
      slot_type [MAX_RESULTS-1:0] res;
      logic [CNT_W-1:0]           cnt;
   } bundle_type;

   typedef struct packed {
      parse_state_type st;
      bundle_type      bnd;
   } work_type;

   function automatic logic is_ws(logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      return v;
   endfunction

   function automatic work_type emit(work_type w, logic [1:0] kind, logic [7:0] d,
                                     logic [SPACES_W-1:0] spaces, logic valid);
      work_type r;
      r = w;
      if (r.bnd.cnt < CNT_W'(MAX_RESULTS)) begin
         r.bnd.res[r.bnd.cnt[SLOT_W-1:0]].kind = kind;
         r.bnd.res[r.bnd.cnt[SLOT_W-1:0]].data = d;
         r.bnd.res[r.bnd.cnt[SLOT_W-1:0]].spaces = spaces;
         r.bnd.res[r.bnd.cnt[SLOT_W-1:0]].valid = valid;
         r.bnd.cnt = r.bnd.cnt + CNT_W'(1);
      end
      return r;
   endfunction

   function automatic work_type end_segment(work_type w);
      work_type r;
      r = emit(w, KIND_END, 8'd0, '0, w.st.saw_equals);
      r.st.phase = PH_BOUNDARY;
      r.st.hex = HEX_IDLE;
      r.st.decoded_count = '0;
      r.st.pending_spaces = '0;
      r.st.saw_equals = 1'b0;
      r.st.field_killed = 1'b0;
      return r;
   endfunction

   function automatic work_type take_decoded(work_type w, logic [7:0] d);
      work_type r;
      r = w;
      if (r.st.phase == PH_NAME) begin
         if (!r.st.field_killed) begin
            if (d == 8'd0) begin
               r.st.field_killed = 1'b1;
            end else if (d == CHAR_EQUALS) begin
               r.st.saw_equals = 1'b1;
               r.st.phase = PH_VLEAD;
            end else begin
               r = emit(r, KIND_NAME, d, '0, 1'b0);
            end
         end
      end else if (!r.st.field_killed) begin
         if (d == 8'd0) begin
            r.st.field_killed = 1'b1;
         end else if (r.st.phase == PH_VLEAD && is_ws(d)) begin
            r.st.field_killed = r.st.field_killed;
         end else if (d == CHAR_SPACE) begin
            if (r.st.pending_spaces != SPACES_MAX)
               r.st.pending_spaces = r.st.pending_spaces + SPACES_W'(1);
         end else begin
            r.st.phase = PH_VBODY;
            r = emit(r, KIND_VALUE, d, r.st.pending_spaces, 1'b0);
            r.st.pending_spaces = '0;
         end
      end
      r.st.decoded_count = r.st.decoded_count + COUNT_W'(1);
      if (r.st.decoded_count >= COUNT_W'(MAX_SEGMENT)) begin
         r = end_segment(r);
         r.st.swallow_separator = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type take_raw(work_type w, logic [7:0] b, logic last,
                                         logic [7:0] sep);
      work_type r;
      logic     done;
      r = w;
      done = 1'b0;
      if (r.st.phase == PH_BOUNDARY) begin
         if (r.st.swallow_separator) begin
            r.st.swallow_separator = 1'b0;
            if (b == sep) done = 1'b1;
         end
         if (!done) r.st.phase = PH_SKIP;
      end
      if (!done && r.st.phase == PH_SKIP) begin
         if (is_ws(b)) done = 1'b1;
         else r.st.phase = PH_NAME;
      end
      if (!done) begin
         if (b == CHAR_PLUS) r = take_decoded(r, CHAR_SPACE);
         else if (b == CHAR_PERCENT && !last) r.st.hex = HEX_FIRST;
         else if (b == sep) r = end_segment(r);
         else r = take_decoded(r, b);
      end
      return r;
   endfunction

   // Full effect of one raw byte: next parse state and the results it causes.
   function automatic work_type parse_step(parse_state_type s, logic [7:0] b, logic last,
                                           logic [7:0] sep);
      work_type w;
      w.st = s;
      w.bnd = '0;
      if (s.hex == HEX_SECOND) begin
         w.st.hex = HEX_IDLE;
         w = take_decoded(w, {hex_val(s.held_hex_char), hex_val(b)});
      end else if (s.hex == HEX_FIRST) begin
         if (!last) begin
            w.st.held_hex_char = b;
            w.st.hex = HEX_SECOND;
         end else begin
            // A percent with too few bytes after it stands for itself.
            w.st.hex = HEX_IDLE;
            if (sep == CHAR_PERCENT) w = end_segment(w);
            else w = take_decoded(w, CHAR_PERCENT);
            w = take_raw(w, b, 1'b1, sep);
         end
      end else begin
         w = take_raw(w, b, last, sep);
      end
      if (last) begin
         if (w.st.phase != PH_BOUNDARY) w = end_segment(w);
         w.st = PARSE_RESET;
      end
      return w;
   endfunction

endpackage

@@ hdl/uqp_front.sv @@
// Front end: accepts raw bytes, runs the decode state and bundles each byte's results.
module uqp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  uqp_pkg::req_item_type req_item,
   output logic                  req_full,
   input  logic [7:0]            separator,
   input  logic                  q_full,
   output logic                  q_push,
   output uqp_pkg::bundle_type   q_bundle
);
   import uqp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   work_type        step;
   logic            accept;

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   always_comb begin
      step = parse_step(state_ff, req_item.raw_byte, req_item.is_last_byte, separator);
      state_in = accept ? step.st : state_ff;
      q_bundle = step.bnd;
      // A beat that causes no result leaves nothing in the queue.
      q_push = accept && (step.bnd.cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.decoded_count < COUNT_W'(MAX_SEGMENT))
      else $error("decoded count reached the segment limit without closing");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.is_last_byte) |=> (state_ff == PARSE_RESET))
      else $error("parse state not cleared after the last byte");

endmodule

@@ hdl/uqp_queue.sv @@
// Short queue of result bundles between the front and back ends.
module uqp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uqp_pkg::bundle_type bundle_in,
   output logic                full,
   input  logic                pop,
   output uqp_pkg::bundle_type bundle_out,
   output logic                empty
);
   import uqp_pkg::*;

   bundle_type          mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign bundle_out = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= bundle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("bundle pushed into a full queue");

   a_pointer_spacing: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with the fill count");

endmodule

@@ hdl/uqp_back.sv @@
// Back end: hands out the results of the oldest bundle one beat at a time.
module uqp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  uqp_pkg::bundle_type   head,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic [1:0]            source_tag,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output uqp_pkg::rsp_item_type rsp_item
);
   import uqp_pkg::*;

   logic [SLOT_W-1:0] index_ff, index_in;
   logic              at_last;
   slot_type          slot;

   assign slot = head.res[index_ff];
   assign at_last = ((CNT_W'(index_ff) + CNT_W'(1)) == head.cnt);
   assign rsp_empty = q_empty;

   always_comb begin
      rsp_item.result_kind = slot.kind;
      rsp_item.data_byte = slot.data;
      rsp_item.spaces_before = slot.spaces;
      rsp_item.pair_valid = slot.valid;
      rsp_item.origin_tag = source_tag;
      rsp_item.last_of_run = at_last;

      q_pop = 1'b0;
      index_in = index_ff;
      if (rsp_pop && !q_empty) begin
         if (at_last) begin
            q_pop = 1'b1;
            index_in = '0;
         end else begin
            index_in = index_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

   a_index_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (CNT_W'(index_ff) < head.cnt))
      else $error("result index points past the end of its bundle");

endmodule

@@ hdl/url_query_pair_parser_top.sv @@
// Top level of the URL query pair parser: control registers and the front, queue and back ends.
//
//  Channel | Ports                              | Moves
//  --------+------------------------------------+-----------------------------------
//  req     | req_push, req_full, req_item       | one raw byte and last flag per beat
//  rsp     | rsp_pop, rsp_empty, rsp_item       | one decoded result per beat
//  csr     | csr_we, csr_index, csr_wdata       | one register write per cycle
//
// A byte is accepted in any cycle the bundle queue has room; a byte causes zero to four
// results, which enter the bundle queue together and reach the rsp ports from its head.
// The rsp side moves one result per cycle while rsp_pop is high, so a byte with k results holds
// the output until all k are popped; the four-entry bundle queue absorbs that while req runs on.
// Synchronous reset clears the parse state, the queue and sets separator '&' and tag 0.
// There is no clearing pass after reset.
module url_query_pair_parser_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  uqp_pkg::req_item_type                req_item,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output uqp_pkg::rsp_item_type                rsp_item,
   input  logic                                 csr_we,
   input  logic [uqp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [uqp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import uqp_pkg::*;

   logic [7:0] separator_ff, separator_in;
   logic [1:0] source_tag_ff, source_tag_in;
   logic       q_push, q_full, q_pop, q_empty;
   bundle_type q_bundle_in, q_head;

   always_comb begin
      separator_in = separator_ff;
      source_tag_in = source_tag_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEPARATOR:  separator_in = csr_wdata[7:0];
            CSR_SOURCE_TAG: source_tag_in = csr_wdata[1:0];
            default:        separator_in = separator_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RESET;
         source_tag_ff <= SOURCE_TAG_RESET;
      end else begin
         separator_ff <= separator_in;
         source_tag_ff <= source_tag_in;
      end
   end

   uqp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .separator (separator_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_bundle  (q_bundle_in)
   );

   uqp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .bundle_in  (q_bundle_in),
      .full       (q_full),
      .pop        (q_pop),
      .bundle_out (q_head),
      .empty      (q_empty)
   );

   uqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .source_tag (source_tag_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule
